// ===== hw/rtl/c3v_pkg.sv =====
package c3v_pkg;

    localparam int KSize        = 3;
    localparam int MaxColsDef   = 64;
    localparam int PixelBitsDef = 16;
    localparam int WeightBits   = 16;

    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 48;
    localparam int FrameColsW = 7;
    localparam int RowW       = 12;
    localparam int OutColW    = 6;
    localparam int SumW       = 40;

    localparam logic [FrameColsW-1:0] FrameColsRst = 7'd8;
    localparam logic [RowW-1:0]       FrameRowsRst = 12'd8;

    localparam logic [CfgIdxW-1:0] CfgWRow0     = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgWRow1     = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgWRow2     = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgFrameCols = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgFrameRows = 3'd4;

endpackage

// ===== hw/rtl/conv2d_3x3_valid.sv =====
// Streaming 3x3 valid convolution, one pixel item per cycle while the input is not stalled.
// Stage 1 registers the nine products of an accepted pixel, stage 2 registers their sum in the
// output register; a new pixel item can be taken while earlier ones are still in the stages.
// Reset (synchronous, active low) restores registers and counters, then a clearing pass
// over all MAX_COLS addresses zeroes both line stores while the input channel stalls.
module conv2d_3x3_valid #(
    parameter int MAX_COLS   = c3v_pkg::MaxColsDef,
    parameter int PIXEL_BITS = c3v_pkg::PixelBitsDef
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [PIXEL_BITS-1:0]         i_pixel,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [c3v_pkg::SumW-1:0]      o_conv_sum,
    output logic        [c3v_pkg::RowW-1:0]      o_out_row,
    output logic        [c3v_pkg::OutColW-1:0]   o_out_col,
    output logic                                 o_frame_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [c3v_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic        [c3v_pkg::CfgDataW-1:0]  i_cfg_data
);
    import c3v_pkg::*;

    localparam int ColAW  = $clog2(MAX_COLS);
    localparam int CmpW   = ($clog2(MAX_COLS + 1) > FrameColsW) ? $clog2(MAX_COLS + 1)
                                                                : FrameColsW;
    localparam int OcW    = (ColAW > OutColW) ? ColAW : OutColW;
    localparam int ProdW  = PIXEL_BITS + WeightBits;
    localparam int AccW   = (ProdW + 4 > SumW) ? ProdW + 4 : SumW;
    localparam int NProd  = KSize * KSize;

    // configuration
    logic [CfgDataW-1:0]   r_w [KSize];
    logic [FrameColsW-1:0] r_frame_cols;
    logic [RowW-1:0]       r_frame_rows;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KSize; i++) begin
                r_w[i] <= '0;
            end
            r_frame_cols <= FrameColsRst;
            r_frame_rows <= FrameRowsRst;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgWRow0:     r_w[0]       <= i_cfg_data;
                CfgWRow1:     r_w[1]       <= i_cfg_data;
                CfgWRow2:     r_w[2]       <= i_cfg_data;
                CfgFrameCols: r_frame_cols <= i_cfg_data[FrameColsW-1:0];
                CfgFrameRows: r_frame_rows <= i_cfg_data[RowW-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    logic r_clearing;
    logic [ColAW-1:0] r_clr;
    logic r_p_valid;
    logic r_out_valid;
    logic adv;
    logic acc;

    assign adv        = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_clearing || !adv;
    assign acc        = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            if (r_clr == ColAW'(MAX_COLS - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr <= r_clr + ColAW'(1);
            end
        end
    end

    // position counters
    logic [ColAW-1:0] r_col;
    logic [RowW-1:0]  r_row;
    logic [CmpW-1:0]  cols_ext;
    logic [CmpW-1:0]  cols_cl;
    logic [RowW-1:0]  rows_cl;
    logic             row_end;
    logic             frame_end;
    logic             has_res;
    logic [ColAW-1:0] n_col;
    logic [OcW-1:0]   oc_full;

    always_comb begin
        cols_ext = CmpW'(r_frame_cols);
        if (cols_ext < CmpW'(3)) begin
            cols_cl = CmpW'(3);
        end else if (cols_ext > CmpW'(MAX_COLS)) begin
            cols_cl = CmpW'(MAX_COLS);
        end else begin
            cols_cl = cols_ext;
        end
        rows_cl   = (r_frame_rows < RowW'(3)) ? RowW'(3) : r_frame_rows;
        row_end   = CmpW'(r_col) >= (cols_cl - CmpW'(1));
        frame_end = row_end && (r_row >= (rows_cl - RowW'(1)));
        has_res   = (r_row >= RowW'(2)) && (r_col >= ColAW'(2));
        n_col     = row_end ? '0 : r_col + ColAW'(1);
        oc_full   = OcW'(r_col) - OcW'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            if (row_end) begin
                r_row <= frame_end ? '0 : r_row + RowW'(1);
            end
        end
    end

    // line stores, read into registers ahead of the pixel that needs them
    logic        [PIXEL_BITS-1:0] mem_a [MAX_COLS];
    logic        [PIXEL_BITS-1:0] mem_b [MAX_COLS];
    logic signed [PIXEL_BITS-1:0] r_rd_a;
    logic signed [PIXEL_BITS-1:0] r_rd_b;
    logic        [ColAW-1:0]      raddr;

    assign raddr = acc ? n_col : r_col;

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem_a[r_clr] <= '0;
            mem_b[r_clr] <= '0;
        end else if (acc) begin
            mem_a[r_col] <= i_pixel;
            mem_b[r_col] <= r_rd_a;
        end
        r_rd_a <= mem_a[raddr];
        r_rd_b <= mem_b[raddr];
    end

    // sliding window
    logic signed [PIXEL_BITS-1:0] r_win [KSize][KSize-1];
    logic signed [PIXEL_BITS-1:0] colv [KSize];

    always_comb begin
        colv[0] = r_rd_b;
        colv[1] = r_rd_a;
        colv[2] = i_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KSize; i++) begin
                for (int j = 0; j < KSize - 1; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (acc) begin
            for (int i = 0; i < KSize; i++) begin
                for (int j = 0; j < KSize - 2; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][KSize-2] <= colv[i];
            end
        end
    end

    // stage 1: products
    logic signed [WeightBits-1:0] wgt [KSize][KSize];
    logic signed [ProdW-1:0]      n_prod [NProd];
    logic signed [ProdW-1:0]      r_prod [NProd];
    logic        [RowW-1:0]       r_p_row;
    logic        [OutColW-1:0]    r_p_col;
    logic                         r_p_last;

    always_comb begin
        for (int i = 0; i < KSize; i++) begin
            for (int j = 0; j < KSize; j++) begin
                wgt[i][j] = r_w[i][WeightBits*j +: WeightBits];
            end
            for (int j = 0; j < KSize - 1; j++) begin
                n_prod[i*KSize+j] = r_win[i][j] * wgt[i][j];
            end
            n_prod[i*KSize+KSize-1] = colv[i] * wgt[i][KSize-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (adv) begin
            r_p_valid <= acc && has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NProd; k++) begin
                r_prod[k] <= n_prod[k];
            end
            r_p_row  <= r_row - RowW'(2);
            r_p_col  <= oc_full[OutColW-1:0];
            r_p_last <= frame_end;
        end
    end

    // stage 2: sum
    logic signed [AccW-1:0] row_sum [KSize];
    logic signed [AccW-1:0] total;
    logic signed [SumW-1:0] r_sum;
    logic [RowW-1:0]        r_o_row;
    logic [OutColW-1:0]     r_o_col;
    logic                   r_o_last;

    always_comb begin
        for (int i = 0; i < KSize; i++) begin
            row_sum[i] = AccW'(r_prod[i*KSize]) + AccW'(r_prod[i*KSize+1])
                       + AccW'(r_prod[i*KSize+2]);
        end
        total = row_sum[0] + row_sum[1] + row_sum[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_p_valid) begin
            r_sum    <= total[SumW-1:0];
            r_o_row  <= r_p_row;
            r_o_col  <= r_p_col;
            r_o_last <= r_p_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_conv_sum   = r_sum;
    assign o_out_row    = r_o_row;
    assign o_out_col    = r_o_col;
    assign o_frame_last = r_o_last;

endmodule

// ===== hw/rtl/c3v_checker.sv =====
module c3v_checker #(
    parameter int PIXEL_BITS = c3v_pkg::PixelBitsDef
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic signed [PIXEL_BITS-1:0]         i_pixel,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [c3v_pkg::SumW-1:0]      o_conv_sum,
    input logic        [c3v_pkg::RowW-1:0]      o_out_row,
    input logic        [c3v_pkg::OutColW-1:0]   o_out_col,
    input logic                                 o_frame_last,
    input logic                                 i_cfg_valid,
    input logic                                 o_cfg_ready
);
    import c3v_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_conv_sum)
            && $stable(o_out_row) && $stable(o_out_col) && $stable(o_frame_last))
        else $error("stalled result item changed");

    // a new result must be preceded by an accepted input item that made it
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_acc, 2))
        else $error("result item without matching input item");

    // once the line stores are cleared, input stalls only behind a stalled result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |=> (!o_in_stall || (o_out_valid && i_out_stall)))
        else $error("input stalled with output free");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_pixel))
        else $error("stalled input item changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind conv2d_3x3_valid c3v_checker #(
    .PIXEL_BITS(PIXEL_BITS)
) u_c3v_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_pixel      (i_pixel),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_conv_sum   (o_conv_sum),
    .o_out_row    (o_out_row),
    .o_out_col    (o_out_col),
    .o_frame_last (o_frame_last),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import c3v_pkg::*;

    localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;
    localparam int unsigned RandomItems = 870;
    localparam int unsigned DrainCycles = 4;
    localparam int unsigned MaxPrinted = 40;

    typedef struct packed {
        logic signed [SumW-1:0] sum;
        logic [RowW-1:0]        row;
        logic [OutColW-1:0]     col;
        logic                   last;
    } t_conv_result;

    typedef struct packed {
        logic [CfgIdxW-1:0]  idx;
        logic [CfgDataW-1:0] data;
    } t_reg_write;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic signed [PixelBitsDef-1:0] i_pixel = '0;
    logic                         i_out_stall = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]           i_cfg_index = CfgWRow0;
    logic [CfgDataW-1:0]          i_cfg_data = '0;

    logic                         o_in_stall;
    logic                         o_out_valid;
    logic signed [SumW-1:0]       o_conv_sum;
    logic [RowW-1:0]              o_out_row;
    logic [OutColW-1:0]           o_out_col;
    logic                         o_frame_last;
    logic                         o_cfg_ready;

    conv2d_3x3_valid i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel      (i_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_conv_sum   (o_conv_sum),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // window sum predictor state
    logic [CfgDataW-1:0]   kern_rows [KSize];
    logic [FrameColsW-1:0] cfg_cols = FrameColsRst;
    logic [RowW-1:0]       cfg_rows = FrameRowsRst;
    logic [15:0]           line_up1 [MaxColsDef];
    logic [15:0]           line_up2 [MaxColsDef];
    logic signed [15:0]    win_taps [KSize][KSize-1];
    int unsigned           pos_col = 0;
    int unsigned           pos_row = 0;

    t_conv_result pending_sums [$];
    t_reg_write   reg_queue [$];
    t_conv_result want_res;

    bit          in_idle_on = 1'b0;
    bit          out_idle_on = 1'b0;
    int unsigned stall_left = 0;
    int unsigned n_errors = 0;
    int unsigned n_items = 0;
    int unsigned n_random = 0;
    int unsigned n_results = 0;
    int unsigned n_frames = 0;
    int unsigned n_cfg_writes = 0;

    initial begin
        for (int i = 0; i < KSize; i++) begin
            kern_rows[i] = '0;
            win_taps[i][0] = '0;
            win_taps[i][1] = '0;
        end
        for (int i = 0; i < MaxColsDef; i++) begin
            line_up1[i] = '0;
            line_up2[i] = '0;
        end
    end

    function automatic void conv_window(input logic [15:0] px);
        int unsigned ncols, nrows, c, r, i, j;
        logic signed [15:0] colv [KSize];
        logic signed [15:0] tap;
        logic signed [15:0] wt;
        logic signed [63:0] acc;
        bit row_end, frame_end;
        t_conv_result res;
        ncols = (cfg_cols < 3) ? 3 : (cfg_cols > MaxColsDef) ? MaxColsDef : cfg_cols;
        nrows = (cfg_rows < 3) ? 3 : cfg_rows;
        c = (pos_col >= MaxColsDef) ? MaxColsDef - 1 : pos_col;
        r = pos_row;
        colv[0] = line_up2[c];
        colv[1] = line_up1[c];
        colv[2] = px;
        row_end = (c >= ncols - 1);
        frame_end = row_end && (r >= nrows - 1);
        if (r >= 2 && c >= 2) begin
            acc = '0;
            for (i = 0; i < KSize; i++) begin
                for (j = 0; j < KSize; j++) begin
                    tap = (j == KSize - 1) ? colv[i] : win_taps[i][j];
                    wt = kern_rows[i][16*j +: 16];
                    acc = acc + tap * wt;
                end
            end
            res.sum = acc[SumW-1:0];
            res.row = RowW'(r - 2);
            res.col = OutColW'(c - 2);
            res.last = frame_end;
            pending_sums.push_back(res);
        end
        line_up2[c] = line_up1[c];
        line_up1[c] = px;
        for (i = 0; i < KSize; i++) begin
            win_taps[i][0] = win_taps[i][1];
            win_taps[i][1] = colv[i];
        end
        if (row_end) begin
            pos_col = 0;
            pos_row = frame_end ? 0 : ((r + 1) & 32'hFFF);
        end else begin
            pos_col = c + 1;
        end
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        if (n_errors <= MaxPrinted)
            $display("MISMATCH t=%0t %s: got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    task automatic queue_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        t_reg_write wr;
        wr.idx = idx;
        wr.data = data;
        reg_queue.push_back(wr);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // writes only once the pipeline is empty
    task automatic program_regs();
        t_reg_write wr;
        drain_results();
        while (reg_queue.size() != 0) begin
            wr = reg_queue.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= wr.idx;
            i_cfg_data <= wr.data;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (wr.idx)
                CfgWRow0:     kern_rows[0] = wr.data;
                CfgWRow1:     kern_rows[1] = wr.data;
                CfgWRow2:     kern_rows[2] = wr.data;
                CfgFrameCols: cfg_cols = wr.data[FrameColsW-1:0];
                CfgFrameRows: cfg_rows = wr.data[RowW-1:0];
                default: ;
            endcase
            n_cfg_writes++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [15:0] px);
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        conv_window(px);
        n_items++;
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (o_frame_last) n_frames++;
            if (pending_sums.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_conv_sum), '0);
            end else begin
                want_res = pending_sums.pop_front();
                if (o_conv_sum !== want_res.sum)
                    report_mismatch("conv_sum", 64'(o_conv_sum), 64'(want_res.sum));
                if (o_out_row !== want_res.row)
                    report_mismatch("out_row", 64'(o_out_row), 64'(want_res.row));
                if (o_out_col !== want_res.col)
                    report_mismatch("out_col", 64'(o_out_col), 64'(want_res.col));
                if (o_frame_last !== want_res.last)
                    report_mismatch("frame_last", 64'(o_frame_last), 64'(want_res.last));
            end
        end
    end

    // sizes left at reset values, so the first result needs two rows plus three pixels
    task automatic test_reset_sizes();
        queue_reg(CfgWRow0, {16'sd3, 16'sd2, 16'sd1});
        queue_reg(CfgWRow1, {-16'sd4, 16'sd5, -16'sd6});
        queue_reg(CfgWRow2, {16'sd9, -16'sd8, 16'sd7});
        program_regs();
        for (int k = 0; k < 2 * FrameColsRst + 3; k++)
            send_pixel(16'(k * 1021 - 9000));
    endtask

    // sizes below the minimum clamp to 3x3; the second size change is applied mid-row
    task automatic test_clamped_extremes();
        queue_reg(CfgWRow0, {3{16'h8000}});
        queue_reg(CfgWRow1, {3{16'h8000}});
        queue_reg(CfgWRow2, {3{16'h8000}});
        queue_reg(CfgFrameCols, 48'd0);
        queue_reg(CfgFrameRows, 48'd1);
        queue_reg(CfgIdxSpare, {48{1'b1}});
        program_regs();
        send_pixel(16'h1234);
        repeat (9) send_pixel(16'h8000);
        queue_reg(CfgFrameCols, 48'd2);
        queue_reg(CfgFrameRows, 48'd2);
        program_regs();
        repeat (9) send_pixel(16'h7FFF);
    endtask

    task automatic test_random_frames();
        int unsigned sel, eff_cols, eff_rows, burst;
        logic [FrameColsW-1:0] cols;
        logic [RowW-1:0] rows;
        while (n_random < RandomItems) begin
            sel = $urandom_range(0, 19);
            if (sel < 2) cols = FrameColsW'($urandom_range(0, 2));
            else if (sel == 2) cols = FrameColsW'(MaxColsDef);
            else if (sel == 3) cols = FrameColsW'($urandom_range(MaxColsDef + 1, 127));
            else cols = FrameColsW'($urandom_range(3, 12));
            sel = $urandom_range(0, 19);
            if (sel < 2) rows = RowW'($urandom_range(0, 2));
            else if (sel == 2) rows = {RowW{1'b1}};
            else rows = RowW'($urandom_range(3, 6));
            queue_reg(CfgWRow0, {pick_value(), pick_value(), pick_value()});
            queue_reg(CfgWRow1, {pick_value(), pick_value(), pick_value()});
            queue_reg(CfgWRow2, {pick_value(), pick_value(), pick_value()});
            queue_reg(CfgFrameCols, CfgDataW'(cols));
            queue_reg(CfgFrameRows, CfgDataW'(rows));
            program_regs();
            in_idle_on = ($urandom_range(0, 2) != 0);
            out_idle_on = ($urandom_range(0, 2) != 0);
            eff_cols = (cols < 3) ? 3 : (cols > MaxColsDef) ? MaxColsDef : cols;
            eff_rows = (rows < 3) ? 3 : (rows > 6) ? 4 : rows;
            burst = eff_cols * eff_rows;
            // some phases stop mid-frame so the next size change lands mid-frame
            if ($urandom_range(0, 3) == 0) burst = $urandom_range(1, burst);
            if (burst > RandomItems - n_random) burst = RandomItems - n_random;
            repeat (burst) begin
                send_pixel(pick_value());
                n_random++;
            end
        end
    endtask

    task automatic test_full_rate();
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        queue_reg(CfgWRow0, {pick_value(), pick_value(), pick_value()});
        queue_reg(CfgWRow1, {pick_value(), pick_value(), pick_value()});
        queue_reg(CfgWRow2, {pick_value(), pick_value(), pick_value()});
        queue_reg(CfgFrameCols, 48'd5);
        queue_reg(CfgFrameRows, 48'd4);
        program_regs();
        repeat (40) send_pixel(pick_value());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_sizes();
        test_clamped_extremes();
        test_random_frames();
        test_full_rate();
        drain_results();
        $display("Run: %0d pixel items in, %0d window sums checked, %0d frames closed.",
                 n_items, n_results, n_frames);
        $display("Run: %0d register writes, sizes from clamped 3x3 up to 64 columns.",
                 n_cfg_writes);
        if (n_errors == 0) begin
            $display("** conv2d_3x3_valid: PASSED **");
        end else begin
            $display("** conv2d_3x3_valid: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TIMEOUT at t=%0t", $time);
        $display("** conv2d_3x3_valid: FAILED **");
        $finish;
    end

endmodule
